// ===== rtl/tbo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tbo_pkg;

	localparam int CW   = 32;                       // coordinate width
	localparam int FW   = 32;                       // input field width
	localparam int HW   = 31;                       // half extent width
	localparam int CFGW = 32;                       // configuration data width
	localparam int VW   = CW + 1;                   // box-relative vertex
	localparam int EW   = CW + 2;                   // edge vector
	localparam int MW   = EW + VW;                  // edge by vertex product
	localparam int PW   = MW + 1;                   // projection
	localparam int RPW  = EW + HW;                  // radius partial product
	localparam int RW   = RPW + 1;                  // radius
	localparam int CMPW = ((PW > RW + 1) ? PW : RW + 1) + 1;
	localparam int NPW  = 2 * EW;                   // normal partial product
	localparam int NW   = NPW + 1;                  // plane normal
	localparam int LW   = (((HW + 1) > VW) ? (HW + 1) : VW) + 1;
	localparam int NLB  = NW / 2;                   // low slice of the normal
	localparam int NHB  = NW - NLB;                 // high slice of the normal
	localparam int QLW  = NLB + 1 + LW;
	localparam int QHW  = NHB + LW;
	localparam int TW   = NW + LW;
	localparam int DW   = TW + 2;
	localparam int DEPTH = 7;
	localparam int CNTW  = $clog2(DEPTH + 1);

	typedef logic [HW-1:0]          half_t;
	typedef logic signed [CW-1:0]   coord_t;
	typedef logic signed [VW-1:0]   vval_t;
	typedef logic signed [EW-1:0]   eval_t;
	typedef logic signed [MW-1:0]   mval_t;
	typedef logic signed [PW-1:0]   pval_t;
	typedef logic [EW-1:0]          emag_t;
	typedef logic [RPW-1:0]         rpart_t;
	typedef logic [RW-1:0]          rval_t;
	typedef logic signed [NPW-1:0]  npart_t;
	typedef logic signed [NW-1:0]   nval_t;
	typedef logic signed [LW-1:0]   lval_t;
	typedef logic signed [CMPW-1:0] cmp_t;
	typedef logic signed [QLW-1:0]  qlo_t;
	typedef logic signed [QHW-1:0]  qhi_t;
	typedef logic signed [TW-1:0]   term_t;
	typedef logic signed [DW-1:0]   dsum_t;

	typedef enum logic [1:0] {
		REG_HALF_X = 2'd0,
		REG_HALF_Y = 2'd1,
		REG_HALF_Z = 2'd2
	} reg_idx_t;

	typedef struct {
		vval_t v [3][3];
		eval_t e [3][3];
		logic  face_sep;
	} vx_item_t;

	typedef struct {
		pval_t p  [3][3][3];
		rval_t rd [3][3];
		nval_t n  [3];
		lval_t am [3];
		lval_t ap [3];
		logic  face_sep;
	} pr_item_t;

	function automatic int nxt(input int k);
		case (k)
			0:       return 1;
			1:       return 2;
			default: return 0;
		endcase
	endfunction

	function automatic coord_t coord(input logic [FW-1:0] f);
		logic signed [FW-1:0] s;
		s = $signed(f);
		return coord_t'(s);
	endfunction

	function automatic lval_t half_ext(input half_t h);
		return lval_t'($signed({1'b0, h}));
	endfunction

endpackage
`default_nettype wire

// ===== rtl/tbo_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface tbo_in_if;
	import tbo_pkg::*;
	logic valid;
	logic ready;
	logic [FW-1:0] center_x, center_y, center_z;
	logic [FW-1:0] a_x, a_y, a_z;
	logic [FW-1:0] b_x, b_y, b_z;
	logic [FW-1:0] c_x, c_y, c_z;
	modport source (output valid, center_x, center_y, center_z, a_x, a_y, a_z,
		b_x, b_y, b_z, c_x, c_y, c_z, input ready);
	modport sink (input valid, center_x, center_y, center_z, a_x, a_y, a_z,
		b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tbo_out_if;
	logic valid;
	logic ready;
	logic overlaps;
	modport source (output valid, overlaps, input ready);
	modport sink (input valid, overlaps, output ready);
endinterface

interface tbo_cfg_if;
	import tbo_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [CFGW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tbo_vertex.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tbo_vertex
	import tbo_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	tbo_in_if.sink      item,
	input  wire half_t  half [3],
	output logic        vld_o,
	input  wire logic   rdy_i,
	output vx_item_t    dat_o
);

	logic   vld_s1, vld_s2, en_s1, en_s2;
	vval_t  v_s1 [3][3];
	vval_t  v_s2 [3][3];
	eval_t  e_s2 [3][3];
	logic   face_sep_s2;
	coord_t cen [3];
	coord_t vert [3][3];
	vval_t  v_d [3][3];
	eval_t  e_d [3][3];
	logic   face_d;
	logic   all_hi, all_lo;

	assign en_s1 = !vld_s1 || en_s2;
	assign en_s2 = !vld_s2 || rdy_i;
	assign item.ready = en_s1;

	always_comb begin
		cen[0] = coord(item.center_x);
		cen[1] = coord(item.center_y);
		cen[2] = coord(item.center_z);
		vert[0][0] = coord(item.a_x); vert[0][1] = coord(item.a_y); vert[0][2] = coord(item.a_z);
		vert[1][0] = coord(item.b_x); vert[1][1] = coord(item.b_y); vert[1][2] = coord(item.b_z);
		vert[2][0] = coord(item.c_x); vert[2][1] = coord(item.c_y); vert[2][2] = coord(item.c_z);
		for (int t = 0; t < 3; t++)
			for (int k = 0; k < 3; k++)
				v_d[t][k] = vval_t'(vert[t][k]) - vval_t'(cen[k]);
	end

	// edges and box-face extents from the relative vertices
	always_comb begin
		face_d = 1'b0;
		all_hi = 1'b0;
		all_lo = 1'b0;
		for (int k = 0; k < 3; k++) begin
			e_d[0][k] = eval_t'(v_s1[1][k]) - eval_t'(v_s1[0][k]);
			e_d[1][k] = eval_t'(v_s1[2][k]) - eval_t'(v_s1[1][k]);
			e_d[2][k] = eval_t'(v_s1[0][k]) - eval_t'(v_s1[2][k]);
			all_hi = 1'b1;
			all_lo = 1'b1;
			for (int t = 0; t < 3; t++) begin
				all_hi = all_hi && (lval_t'(v_s1[t][k]) > half_ext(half[k]));
				all_lo = all_lo && (lval_t'(v_s1[t][k]) < -half_ext(half[k]));
			end
			face_d = face_d || all_hi || all_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= item.valid;
			if (en_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && item.valid) v_s1 <= v_d;
		if (en_s2 && vld_s1) begin
			v_s2        <= v_s1;
			e_s2        <= e_d;
			face_sep_s2 <= face_d;
		end
	end

	assign vld_o = vld_s2;
	always_comb begin
		dat_o.v        = v_s2;
		dat_o.e        = e_s2;
		dat_o.face_sep = face_sep_s2;
	end

endmodule
`default_nettype wire

// ===== rtl/tbo_product.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tbo_product
	import tbo_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     vld_i,
	output logic          rdy_o,
	input  wire vx_item_t dat_i,
	input  wire half_t    half [3],
	output logic          vld_o,
	input  wire logic     rdy_i,
	output pr_item_t      dat_o
);

	logic   vld_s3, vld_s4, en_s3, en_s4;
	mval_t  m1_s3 [3][3][3];
	mval_t  m2_s3 [3][3][3];
	rpart_t r1_s3 [3][3];
	rpart_t r2_s3 [3][3];
	npart_t na_s3 [3];
	npart_t nb_s3 [3];
	lval_t  am_s3 [3];
	lval_t  ap_s3 [3];
	logic   face_s3;
	pval_t  p_s4 [3][3][3];
	rval_t  rd_s4 [3][3];
	nval_t  n_s4 [3];
	lval_t  am_s4 [3];
	lval_t  ap_s4 [3];
	logic   face_s4;
	mval_t  m1_d [3][3][3];
	mval_t  m2_d [3][3][3];
	rpart_t r1_d [3][3];
	rpart_t r2_d [3][3];
	npart_t na_d [3];
	npart_t nb_d [3];
	lval_t  am_d [3];
	lval_t  ap_d [3];
	emag_t  mag [3][3];

	assign en_s3 = !vld_s3 || en_s4;
	assign en_s4 = !vld_s4 || rdy_i;
	assign rdy_o = en_s3;

	// products for each edge and axis; the axis index rotates with k
	always_comb begin
		for (int ed = 0; ed < 3; ed++)
			for (int k = 0; k < 3; k++)
				mag[ed][k] = dat_i.e[ed][k][EW-1] ? emag_t'(-dat_i.e[ed][k])
					: emag_t'(dat_i.e[ed][k]);
		for (int ed = 0; ed < 3; ed++)
			for (int k = 0; k < 3; k++) begin
				for (int t = 0; t < 3; t++) begin
					m1_d[ed][k][t] = mval_t'(dat_i.e[ed][nxt(nxt(k))])
						* mval_t'(dat_i.v[t][nxt(k)]);
					m2_d[ed][k][t] = mval_t'(dat_i.e[ed][nxt(k)])
						* mval_t'(dat_i.v[t][nxt(nxt(k))]);
				end
				r1_d[ed][k] = rpart_t'(mag[ed][nxt(nxt(k))]) * rpart_t'(half[nxt(k)]);
				r2_d[ed][k] = rpart_t'(mag[ed][nxt(k)]) * rpart_t'(half[nxt(nxt(k))]);
			end
		for (int k = 0; k < 3; k++) begin
			na_d[k] = npart_t'(dat_i.e[0][nxt(k)]) * npart_t'(dat_i.e[1][nxt(nxt(k))]);
			nb_d[k] = npart_t'(dat_i.e[0][nxt(nxt(k))]) * npart_t'(dat_i.e[1][nxt(k)]);
			am_d[k] = -half_ext(half[k]) - lval_t'(dat_i.v[0][k]);
			ap_d[k] = half_ext(half[k]) - lval_t'(dat_i.v[0][k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s3) vld_s3 <= vld_i;
			if (en_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && vld_i) begin
			m1_s3   <= m1_d;
			m2_s3   <= m2_d;
			r1_s3   <= r1_d;
			r2_s3   <= r2_d;
			na_s3   <= na_d;
			nb_s3   <= nb_d;
			am_s3   <= am_d;
			ap_s3   <= ap_d;
			face_s3 <= dat_i.face_sep;
		end
		if (en_s4 && vld_s3) begin
			for (int ed = 0; ed < 3; ed++)
				for (int k = 0; k < 3; k++) begin
					for (int t = 0; t < 3; t++)
						p_s4[ed][k][t] <= pval_t'(m1_s3[ed][k][t]) - pval_t'(m2_s3[ed][k][t]);
					rd_s4[ed][k] <= rval_t'(r1_s3[ed][k]) + rval_t'(r2_s3[ed][k]);
				end
			for (int k = 0; k < 3; k++)
				n_s4[k] <= nval_t'(na_s3[k]) - nval_t'(nb_s3[k]);
			am_s4   <= am_s3;
			ap_s4   <= ap_s3;
			face_s4 <= face_s3;
		end
	end

	assign vld_o = vld_s4;
	always_comb begin
		dat_o.p        = p_s4;
		dat_o.rd       = rd_s4;
		dat_o.n        = n_s4;
		dat_o.am       = am_s4;
		dat_o.ap       = ap_s4;
		dat_o.face_sep = face_s4;
	end

endmodule
`default_nettype wire

// ===== rtl/tbo_axis.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tbo_axis
	import tbo_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     vld_i,
	output logic          rdy_o,
	input  wire pr_item_t dat_i,
	tbo_out_if.source     result
);

	logic  vld_s5, vld_s6, vld_s7, en_s5, en_s6, en_s7;
	logic  sep_s5, sep_s6;
	qlo_t  pl_lo_s5 [3];
	qhi_t  ph_lo_s5 [3];
	qlo_t  pl_hi_s5 [3];
	qhi_t  ph_hi_s5 [3];
	term_t t_lo_s6 [3];
	term_t t_hi_s6 [3];
	logic  ovl_s7;
	logic  sep_d, all_hi, all_lo;
	cmp_t  rc;
	lval_t lo [3];
	lval_t hi [3];
	qlo_t  pl_lo_d [3];
	qhi_t  ph_lo_d [3];
	qlo_t  pl_hi_d [3];
	qhi_t  ph_hi_d [3];
	dsum_t dmin, dmax;

	assign en_s5 = !vld_s5 || en_s6;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s7 = !vld_s7 || result.ready;
	assign rdy_o = en_s5;

	// edge-axis separation, and the plane normal split into two slices
	always_comb begin
		sep_d  = dat_i.face_sep;
		all_hi = 1'b0;
		all_lo = 1'b0;
		rc     = '0;
		for (int ed = 0; ed < 3; ed++)
			for (int k = 0; k < 3; k++) begin
				rc = $signed(cmp_t'(dat_i.rd[ed][k]));
				all_hi = 1'b1;
				all_lo = 1'b1;
				for (int t = 0; t < 3; t++) begin
					all_hi = all_hi && (cmp_t'(dat_i.p[ed][k][t]) > rc);
					all_lo = all_lo && (cmp_t'(dat_i.p[ed][k][t]) < -rc);
				end
				sep_d = sep_d || all_hi || all_lo;
			end
		for (int k = 0; k < 3; k++) begin
			if (dat_i.n[k] > nval_t'(0)) begin
				lo[k] = dat_i.am[k];
				hi[k] = dat_i.ap[k];
			end else begin
				lo[k] = dat_i.ap[k];
				hi[k] = dat_i.am[k];
			end
			pl_lo_d[k] = qlo_t'($signed({1'b0, dat_i.n[k][NLB-1:0]})) * qlo_t'(lo[k]);
			ph_lo_d[k] = qhi_t'($signed(dat_i.n[k][NW-1:NLB])) * qhi_t'(lo[k]);
			pl_hi_d[k] = qlo_t'($signed({1'b0, dat_i.n[k][NLB-1:0]})) * qlo_t'(hi[k]);
			ph_hi_d[k] = qhi_t'($signed(dat_i.n[k][NW-1:NLB])) * qhi_t'(hi[k]);
		end
	end

	always_comb begin
		dmin = '0;
		dmax = '0;
		for (int k = 0; k < 3; k++) begin
			dmin = dmin + dsum_t'(t_lo_s6[k]);
			dmax = dmax + dsum_t'(t_hi_s6[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en_s5) vld_s5 <= vld_i;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && vld_i) begin
			sep_s5   <= sep_d;
			pl_lo_s5 <= pl_lo_d;
			ph_lo_s5 <= ph_lo_d;
			pl_hi_s5 <= pl_hi_d;
			ph_hi_s5 <= ph_hi_d;
		end
		if (en_s6 && vld_s5) begin
			sep_s6 <= sep_s5;
			for (int k = 0; k < 3; k++) begin
				t_lo_s6[k] <= (term_t'(ph_lo_s5[k]) <<< NLB) + term_t'(pl_lo_s5[k]);
				t_hi_s6[k] <= (term_t'(ph_hi_s5[k]) <<< NLB) + term_t'(pl_hi_s5[k]);
			end
		end
		if (en_s7 && vld_s6)
			ovl_s7 <= !sep_s6 && !(dmin > dsum_t'(0)) && !(dmax < dsum_t'(0));
	end

	assign result.valid    = vld_s7;
	assign result.overlaps = ovl_s7;

endmodule
`default_nettype wire

// ===== rtl/triangle_box_overlap_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Triangle against axis-aligned box overlap, separating-axis test. Each request
// carries a box centre and three vertices in signed Q16.16; the box half
// extents come from three configuration registers (reset 0.5 each, writes
// masked to 31 bits, unknown indexes ignored, port always ready). The result
// is one flag, set when the shapes overlap or touch. All arithmetic is exact.
// The unit is a seven-stage pipeline: relative vertices, edges and face test,
// products, projections and normal, edge-axis test with normal slices, plane
// terms, plane sums and decision. Ready runs back from the output through every
// stage, so an empty stage lets the stages behind it advance; a waiting result
// holds the last stage and, once the stages behind it have filled, the input
// as well.
// Throughput is one request per cycle while results are taken, since every
// stage, the multipliers included, accepts a new request each cycle.
module triangle_box_overlap_unit
	import tbo_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	tbo_cfg_if.sink   cfg,
	tbo_in_if.sink    item,
	tbo_out_if.source result
);

	half_t    half_q [3];
	logic     vx_vld, vx_rdy, pr_vld, pr_rdy;
	vx_item_t vx_dat;
	pr_item_t pr_dat;
	logic [CNTW-1:0] cnt_q;

	// configuration: always take the request
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q[0] <= half_t'(32768);
			half_q[1] <= half_t'(32768);
			half_q[2] <= half_t'(32768);
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_HALF_X: half_q[0] <= cfg.data[HW-1:0];
				REG_HALF_Y: half_q[1] <= cfg.data[HW-1:0];
				REG_HALF_Z: half_q[2] <= cfg.data[HW-1:0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	tbo_vertex u_vertex (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.half   (half_q),
		.vld_o  (vx_vld),
		.rdy_i  (vx_rdy),
		.dat_o  (vx_dat)
	);

	tbo_product u_product (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (vx_vld),
		.rdy_o  (vx_rdy),
		.dat_i  (vx_dat),
		.half   (half_q),
		.vld_o  (pr_vld),
		.rdy_i  (pr_rdy),
		.dat_o  (pr_dat)
	);

	tbo_axis u_axis (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (pr_vld),
		.rdy_o  (pr_rdy),
		.dat_i  (pr_dat),
		.result (result)
	);

	// track requests in flight for the checks below
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({item.valid && item.ready, result.valid && result.ready})
				2'b10:   cnt_q <= cnt_q + CNTW'(1);
				2'b01:   cnt_q <= cnt_q - CNTW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_full_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (result.valid && !result.ready))
		else $error("input held off while output drains");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (cnt_q != '0))
		else $error("result with no request in flight");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(DEPTH))
		else $error("more requests in flight than pipeline stages");

endmodule
`default_nettype wire
